@@ hdl/cfdc8_pkg.sv @@
// Shared constants and types for the CRC-8 frame deframer.
package cfdc8_pkg;

  localparam int unsigned FRAME_LEN = 24;
  localparam int unsigned STORE_DEPTH = 20;
  localparam int unsigned ADDR_W = 5;

  localparam logic [4:0] STORE_BASE = 5'd3;
  localparam logic [4:0] CRC_LAST = 5'(FRAME_LEN - 1);
  localparam logic [4:0] LEN_FULL = 5'(FRAME_LEN);

  localparam logic [7:0] MAGIC_0 = 8'hA7;
  localparam logic [7:0] MAGIC_1 = 8'h50;
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Status codes.
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_LENGTH = 3'd1;
  localparam logic [2:0] ST_MAGIC = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_CRC = 3'd4;
  localparam logic [2:0] ST_KIND = 3'd5;
  localparam logic [2:0] ST_MODE = 3'd6;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_VERSION = 3'd0;
  localparam logic [2:0] REG_KIND_MIN = 3'd1;
  localparam logic [2:0] REG_KIND_MAX = 3'd2;
  localparam logic [2:0] REG_MODE_MIN = 3'd3;
  localparam logic [2:0] REG_MODE_MAX = 3'd4;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         kind;
    logic [7:0]         mode;
    logic [7:0]         flag_bits;
    logic [31:0]        sequence_res;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic [15:0]        held_buttons;
    logic [15:0]        button_edges;
    logic [7:0]         agent_command;
  } result_t;

endpackage

@@ hdl/cfdc8_if.sv @@
// Valid/ready channel interfaces for received bytes and decoded frames.
interface cfdc8_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface cfdc8_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         kind;
  logic [7:0]         mode;
  logic [7:0]         flag_bits;
  logic [31:0]        sequence_res;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  logic signed [15:0] yaw;
  logic signed [15:0] pitch;
  logic [15:0]        held_buttons;
  logic [15:0]        button_edges;
  logic [7:0]         agent_command;

  modport source (output valid, output status, output kind, output mode, output flag_bits,
                  output sequence_res, output stick_x, output stick_y, output yaw,
                  output pitch, output held_buttons, output button_edges,
                  output agent_command, input ready);
  modport sink (input valid, input status, input kind, input mode, input flag_bits,
                input sequence_res, input stick_x, input stick_y, input yaw,
                input pitch, input held_buttons, input button_edges,
                input agent_command, output ready);
endinterface

@@ hdl/controller_frame_decoder_crc8_top.sv @@
// Top level of the fixed-length controller frame deframer with CRC-8 check.
//
// Takes one received byte per clock and gives one decoded result at each byte marked
// frame_end. Every byte is processed in the cycle it is accepted: a byte-wide CRC-8
// (polynomial 0x07) and the field capture registers update at that edge, and the
// result of a closing byte goes to the output register, or to the skid register
// while the output register holds an untaken result. The sustained rate is one
// byte per cycle. A two-entry output buffer (output register plus skid register)
// keeps the byte input open while a finished result waits; input stalls only when
// both entries hold results. Frames must be 24 bytes (magic A7 50, version, 20
// payload bytes, CRC); any failed check gives a nonzero status with zeroed fields.
module controller_frame_decoder_crc8_top (
  input  logic                        clk,
  input  logic                        rst,
  cfdc8_rx_if.sink                    rx,
  cfdc8_res_if.source                 res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfdc8_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cfdc8_pkg::*;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Configuration registers.
  logic [7:0] protocol_version, kind_min, kind_max, mode_min, mode_max;

  // Frame state.
  logic [4:0] byte_index;
  logic [7:0] running_crc;
  logic [2:0] first_fault;
  logic [7:0] payload_store [STORE_DEPTH];

  // Output buffer.
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;

  logic       rx_acc, res_take, cfg_wr;
  logic       in_frame, len_bad, crc_bad;
  logic [2:0] byte_fault;
  logic [2:0] status_calc;
  logic [7:0] crc_calc;
  result_t    result_calc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= 8'd1;
      kind_min <= 8'd0;
      kind_max <= 8'd2;
      mode_min <= 8'd0;
      mode_max <= 8'd3;
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_VERSION:  protocol_version <= pwdata[7:0];
        REG_KIND_MIN: kind_min <= pwdata[7:0];
        REG_KIND_MAX: kind_max <= pwdata[7:0];
        REG_MODE_MIN: mode_min <= pwdata[7:0];
        REG_MODE_MAX: mode_max <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_VERSION:  prdata = {24'd0, protocol_version};
      REG_KIND_MIN: prdata = {24'd0, kind_min};
      REG_KIND_MAX: prdata = {24'd0, kind_max};
      REG_MODE_MIN: prdata = {24'd0, mode_min};
      REG_MODE_MAX: prdata = {24'd0, mode_max};
      default:      prdata = 32'd0;
    endcase
  end

  assign rx.ready = !skid_valid;
  assign rx_acc = rx.valid && rx.ready;
  assign res_take = out_valid && res.ready;

  always_comb begin
    in_frame = byte_index < LEN_FULL;
    crc_calc = crc8_byte(running_crc, rx.rx_byte);
    len_bad = byte_index != CRC_LAST;
    crc_bad = (byte_index == CRC_LAST) && (rx.rx_byte != running_crc);

    byte_fault = ST_OK;
    if ((byte_index == 5'd0 && rx.rx_byte != MAGIC_0) ||
        (byte_index == 5'd1 && rx.rx_byte != MAGIC_1)) begin
      byte_fault = ST_MAGIC;
    end else if (byte_index == 5'd2 && rx.rx_byte != protocol_version) begin
      byte_fault = ST_VERSION;
    end

    if (len_bad) begin
      status_calc = ST_LENGTH;
    end else if (first_fault != ST_OK) begin
      status_calc = first_fault;
    end else if (crc_bad) begin
      status_calc = ST_CRC;
    end else if (payload_store[0] < kind_min || payload_store[0] > kind_max) begin
      status_calc = ST_KIND;
    end else if (payload_store[1] < mode_min || payload_store[1] > mode_max) begin
      status_calc = ST_MODE;
    end else begin
      status_calc = ST_OK;
    end

    result_calc = '0;
    result_calc.status = status_calc;
    if (status_calc == ST_OK) begin
      result_calc.kind = payload_store[0];
      result_calc.mode = payload_store[1];
      result_calc.flag_bits = payload_store[2];
      result_calc.sequence_res = {payload_store[6], payload_store[5],
                                  payload_store[4], payload_store[3]};
      result_calc.stick_x = {payload_store[8], payload_store[7]};
      result_calc.stick_y = {payload_store[10], payload_store[9]};
      result_calc.yaw = {payload_store[12], payload_store[11]};
      result_calc.pitch = {payload_store[14], payload_store[13]};
      result_calc.held_buttons = {payload_store[16], payload_store[15]};
      result_calc.button_edges = {payload_store[18], payload_store[17]};
      result_calc.agent_command = payload_store[19];
    end
  end

  // Frame state advances on each accepted byte up to the frame length and clears at a frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      running_crc <= '0;
      first_fault <= ST_OK;
    end else if (rx_acc) begin
      if (rx.frame_end) begin
        byte_index <= '0;
        running_crc <= '0;
        first_fault <= ST_OK;
      end else if (in_frame) begin
        byte_index <= byte_index + 5'd1;
        if (byte_index < CRC_LAST) begin
          running_crc <= crc_calc;
        end
        if (first_fault == ST_OK) begin
          first_fault <= byte_fault;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_acc) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
        if (byte_index == 5'(k + STORE_BASE)) begin
          payload_store[k] <= rx.rx_byte;
        end
      end
    end
  end

  // A new result goes to the output register when it is free or being drained,
  // otherwise it parks in the skid register until the output register empties.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (res_take) begin
        skid_valid <= 1'b0;
      end
    end else if (rx_acc && rx.frame_end) begin
      if (!out_valid || res_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (res_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (res_take) begin
        out_data <= skid_data;
      end
    end else if (rx_acc && rx.frame_end) begin
      if (!out_valid || res_take) begin
        out_data <= result_calc;
      end else begin
        skid_data <= result_calc;
      end
    end
  end

  assign res.valid = out_valid;
  assign res.status = out_data.status;
  assign res.kind = out_data.kind;
  assign res.mode = out_data.mode;
  assign res.flag_bits = out_data.flag_bits;
  assign res.sequence_res = out_data.sequence_res;
  assign res.stick_x = out_data.stick_x;
  assign res.stick_y = out_data.stick_y;
  assign res.yaw = out_data.yaw;
  assign res.pitch = out_data.pitch;
  assign res.held_buttons = out_data.held_buttons;
  assign res.button_edges = out_data.button_edges;
  assign res.agent_command = out_data.agent_command;

endmodule

@@ hdl/cfdc8_checker.sv @@
// Port-level assertions for the frame deframer and the bind that attaches them.
module cfdc8_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_status,
  input logic [7:0]  res_kind,
  input logic [7:0]  res_mode,
  input logic [31:0] res_sequence_res,
  input logic [15:0] res_held_buttons
);
  import cfdc8_pkg::*;

  // A failed frame never leaks decoded data.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_OK |->
      res_kind == 8'd0 && res_mode == 8'd0 && res_sequence_res == 32'd0 &&
      res_held_buttons == 16'd0)
    else $error("error result carries nonzero fields");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_status <= ST_MODE)
    else $error("result status out of range");

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_stall_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_status) && $stable(res_sequence_res))
    else $error("stalled result changed");

endmodule

bind controller_frame_decoder_crc8_top cfdc8_checker u_cfdc8_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_status(res.status),
  .res_kind(res.kind),
  .res_mode(res.mode),
  .res_sequence_res(res.sequence_res),
  .res_held_buttons(res.held_buttons)
);

@@ tb/deframe_tb_pkg.sv @@
// Testbench helper package: the byte-wide CRC-8 update used for frame building and prediction.
package deframe_tb_pkg;
  import cfdc8_pkg::*;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ tb/frame_checker.sv @@
// Checker that predicts decoded frames from accepted bytes and compares them with the results.
module frame_checker (
  input  logic                         clk,
  input  logic                         rst,
  cfdc8_rx_if                          rx,
  cfdc8_res_if                         res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfdc8_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  input  logic                         pready,
  input  logic                         wrap_up,
  output int                           mismatches,
  output int                           frames_owed,
  output int                           frames_checked,
  output int                           frames_ok
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfdc8_pkg::*;
  import deframe_tb_pkg::*;

  logic [7:0] cfg_version, cfg_kind_lo, cfg_kind_hi, cfg_mode_lo, cfg_mode_hi;
  logic [4:0] byte_pos;
  logic [7:0] crc_acc;
  logic [2:0] fault;
  logic [7:0] payload [STORE_DEPTH];
  result_t    decoded_due[$];
  bit         leftovers_reported;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [7:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_VERSION:  return cfg_version;
      REG_KIND_MIN: return cfg_kind_lo;
      REG_KIND_MAX: return cfg_kind_hi;
      REG_MODE_MIN: return cfg_mode_lo;
      REG_MODE_MAX: return cfg_mode_hi;
      default:      return 8'h00;
    endcase
  endfunction

  // Advances the frame state by one byte; returns 1 with the decoded frame on a closing byte.
  function automatic bit decode_byte(input logic [7:0] b, input logic last, output result_t r);
    logic [4:0] pos;
    bit         crc_bad;
    logic [2:0] st;
    pos = byte_pos;
    crc_bad = 0;
    r = '0;
    if (pos < LEN_FULL) begin
      if (fault == ST_OK) begin
        if ((pos == 0 && b != MAGIC_0) || (pos == 1 && b != MAGIC_1)) fault = ST_MAGIC;
        else if (pos == 2 && b != cfg_version) fault = ST_VERSION;
      end
      if (pos >= STORE_BASE && pos < CRC_LAST) payload[pos - STORE_BASE] = b;
      if (pos < CRC_LAST) crc_acc = crc8_update(crc_acc, b);
      else crc_bad = (b != crc_acc);
      byte_pos = pos + 5'd1;
    end
    if (!last) return 0;
    if (pos != CRC_LAST) st = ST_LENGTH;
    else if (fault != ST_OK) st = fault;
    else if (crc_bad) st = ST_CRC;
    else if (payload[0] < cfg_kind_lo || payload[0] > cfg_kind_hi) st = ST_KIND;
    else if (payload[1] < cfg_mode_lo || payload[1] > cfg_mode_hi) st = ST_MODE;
    else st = ST_OK;
    r.status = st;
    if (st == ST_OK) begin
      r.kind          = payload[0];
      r.mode          = payload[1];
      r.flag_bits     = payload[2];
      r.sequence_res  = {payload[6], payload[5], payload[4], payload[3]};
      r.stick_x       = {payload[8], payload[7]};
      r.stick_y       = {payload[10], payload[9]};
      r.yaw           = {payload[12], payload[11]};
      r.pitch         = {payload[14], payload[13]};
      r.held_buttons  = {payload[16], payload[15]};
      r.button_edges  = {payload[18], payload[17]};
      r.agent_command = payload[19];
    end
    byte_pos = '0;
    crc_acc = '0;
    fault = ST_OK;
    return 1;
  endfunction

  task automatic compare_frame(input result_t got, input result_t want);
    int n;
    n = frames_checked;
    if (got.status !== want.status)
      report_mismatch($sformatf("frame %0d status %0d, want %0d", n, got.status, want.status));
    if (got.kind !== want.kind)
      report_mismatch($sformatf("frame %0d kind %h, want %h", n, got.kind, want.kind));
    if (got.mode !== want.mode)
      report_mismatch($sformatf("frame %0d mode %h, want %h", n, got.mode, want.mode));
    if (got.flag_bits !== want.flag_bits)
      report_mismatch($sformatf("frame %0d flags %h, want %h", n, got.flag_bits,
                                want.flag_bits));
    if (got.sequence_res !== want.sequence_res)
      report_mismatch($sformatf("frame %0d sequence %h, want %h", n, got.sequence_res,
                                want.sequence_res));
    if (got.stick_x !== want.stick_x)
      report_mismatch($sformatf("frame %0d stick_x %0d, want %0d", n, got.stick_x,
                                want.stick_x));
    if (got.stick_y !== want.stick_y)
      report_mismatch($sformatf("frame %0d stick_y %0d, want %0d", n, got.stick_y,
                                want.stick_y));
    if (got.yaw !== want.yaw)
      report_mismatch($sformatf("frame %0d yaw %0d, want %0d", n, got.yaw, want.yaw));
    if (got.pitch !== want.pitch)
      report_mismatch($sformatf("frame %0d pitch %0d, want %0d", n, got.pitch, want.pitch));
    if (got.held_buttons !== want.held_buttons)
      report_mismatch($sformatf("frame %0d held buttons %h, want %h", n, got.held_buttons,
                                want.held_buttons));
    if (got.button_edges !== want.button_edges)
      report_mismatch($sformatf("frame %0d button edges %h, want %h", n, got.button_edges,
                                want.button_edges));
    if (got.agent_command !== want.agent_command)
      report_mismatch($sformatf("frame %0d command %h, want %h", n, got.agent_command,
                                want.agent_command));
  endtask

  initial begin
    mismatches = 0;
    frames_owed = 0;
    frames_checked = 0;
    frames_ok = 0;
    leftovers_reported = 0;
  end

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      cfg_version = 8'd1;
      cfg_kind_lo = 8'd0;
      cfg_kind_hi = 8'd2;
      cfg_mode_lo = 8'd0;
      cfg_mode_hi = 8'd3;
      byte_pos = '0;
      crc_acc = '0;
      fault = ST_OK;
      foreach (payload[i]) payload[i] = '0;
      decoded_due = {};
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[4:2])
            REG_VERSION:  cfg_version = pwdata[7:0];
            REG_KIND_MIN: cfg_kind_lo = pwdata[7:0];
            REG_KIND_MAX: cfg_kind_hi = pwdata[7:0];
            REG_MODE_MIN: cfg_mode_lo = pwdata[7:0];
            REG_MODE_MAX: cfg_mode_hi = pwdata[7:0];
            default: ;
          endcase
        end else if (prdata[7:0] !== reg_value(paddr[4:2])) begin
          report_mismatch($sformatf("register %0d reads %h, want %h", paddr[4:2],
                                    prdata[7:0], reg_value(paddr[4:2])));
        end
      end
      if (rx.valid && rx.ready) begin
        if (decode_byte(rx.rx_byte, rx.frame_end, want)) decoded_due.push_back(want);
      end
      if (res.valid && res.ready) begin
        got.status        = res.status;
        got.kind          = res.kind;
        got.mode          = res.mode;
        got.flag_bits     = res.flag_bits;
        got.sequence_res  = res.sequence_res;
        got.stick_x       = res.stick_x;
        got.stick_y       = res.stick_y;
        got.yaw           = res.yaw;
        got.pitch         = res.pitch;
        got.held_buttons  = res.held_buttons;
        got.button_edges  = res.button_edges;
        got.agent_command = res.agent_command;
        if (decoded_due.size() == 0) begin
          report_mismatch($sformatf("result with status %0d arrived with no frame pending",
                                    got.status));
        end else begin
          want = decoded_due.pop_front();
          compare_frame(got, want);
          if (want.status == ST_OK) frames_ok++;
          frames_checked++;
        end
      end
      if (wrap_up && !leftovers_reported && decoded_due.size() != 0) begin
        report_mismatch($sformatf("%0d frames never produced a result", decoded_due.size()));
        leftovers_reported = 1;
      end
    end
    frames_owed = decoded_due.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the deframer testbench: clock, reset, byte and register stimulus, and the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cfdc8_pkg::*;
  import deframe_tb_pkg::*;

  localparam int FILL_ZERO = 0;
  localparam int FILL_ONES = 1;
  localparam int FILL_MIN = 2;
  localparam int FILL_MAX = 3;
  localparam int FILL_RANDOM = 4;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic wrap_up;
  int mismatches, frames_owed, frames_checked, frames_ok;

  bit calm;
  bit hold_results;
  int bytes_sent;
  int settings_used;
  logic [7:0] cur_ver, cur_kind_lo, cur_kind_hi, cur_mode_lo, cur_mode_hi;
  logic [7:0] frame_buf[$];

  cfdc8_rx_if rx_ch();
  cfdc8_res_if res_ch();

  controller_frame_decoder_crc8_top uut (
    .clk(clk), .rst(rst), .rx(rx_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  frame_checker chk (
    .clk(clk), .rst(rst), .rx(rx_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready), .wrap_up(wrap_up),
    .mismatches(mismatches), .frames_owed(frames_owed),
    .frames_checked(frames_checked), .frames_ok(frames_ok)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("timeout: results stopped arriving");
    $display("simulation failed");
    $finish;
  end

  // Each call starts right after the previous transaction, so valid is only
  // dropped when a gap is drawn.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    rx_ch.frame_end <= last;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) push_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (frames_owed != 0) @(negedge clk);
  endtask

  task automatic reg_access(input logic [2:0] idx, input logic wr, input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] ver, input logic [7:0] klo,
                                input logic [7:0] khi, input logic [7:0] mlo,
                                input logic [7:0] mhi);
    wait_drained();
    // Let the output stage settle after the last result before the registers are written.
    repeat (4) @(negedge clk);
    reg_access(REG_VERSION, 1'b1, ver);
    reg_access(REG_KIND_MIN, 1'b1, klo);
    reg_access(REG_KIND_MAX, 1'b1, khi);
    reg_access(REG_MODE_MIN, 1'b1, mlo);
    reg_access(REG_MODE_MAX, 1'b1, mhi);
    reg_access(REG_VERSION, 1'b0, 8'h00);
    reg_access(REG_KIND_MIN, 1'b0, 8'h00);
    reg_access(REG_KIND_MAX, 1'b0, 8'h00);
    reg_access(REG_MODE_MIN, 1'b0, 8'h00);
    reg_access(REG_MODE_MAX, 1'b0, 8'h00);
    cur_ver = ver;
    cur_kind_lo = klo;
    cur_kind_hi = khi;
    cur_mode_lo = mlo;
    cur_mode_hi = mhi;
    settings_used++;
  endtask

  // Builds a well-formed frame with a correct CRC for the current version setting.
  task automatic build_frame(input logic [7:0] kind, input logic [7:0] mode, input int fill);
    logic [7:0] crc;
    logic [7:0] b;
    frame_buf = {};
    frame_buf.push_back(MAGIC_0);
    frame_buf.push_back(MAGIC_1);
    frame_buf.push_back(cur_ver);
    frame_buf.push_back(kind);
    frame_buf.push_back(mode);
    for (int off = 5; off < CRC_LAST; off++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        FILL_MIN:  b = (off % 2) ? 8'h80 : 8'h00;
        FILL_MAX:  b = (off % 2) ? 8'h7F : 8'hFF;
        default:   b = 8'($urandom);
      endcase
      frame_buf.push_back(b);
    end
    crc = '0;
    foreach (frame_buf[i]) crc = crc8_update(crc, frame_buf[i]);
    frame_buf.push_back(crc);
  endtask

  task automatic random_frame();
    int pick;
    int len;
    logic [7:0] kind, mode;
    if ($urandom_range(0, 19) == 0) wait_drained();
    pick = $urandom_range(0, 99);
    kind = (cur_kind_lo <= cur_kind_hi) ? 8'($urandom_range(cur_kind_hi, cur_kind_lo))
                                        : 8'($urandom);
    mode = (cur_mode_lo <= cur_mode_hi) ? 8'($urandom_range(cur_mode_hi, cur_mode_lo))
                                        : 8'($urandom);
    if (pick >= 60 && pick < 65) kind = 8'($urandom);
    if (pick >= 65 && pick < 70) mode = 8'($urandom);
    build_frame(kind, mode, FILL_RANDOM);
    if (pick >= 70 && pick < 75) begin
      frame_buf[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    end else if (pick >= 75 && pick < 80) begin
      frame_buf[2] ^= 8'($urandom_range(1, 255));
    end else if (pick >= 80 && pick < 87) begin
      frame_buf[CRC_LAST] ^= 8'($urandom_range(1, 255));
    end else if (pick >= 87 && pick < 92) begin
      len = $urandom_range(1, FRAME_LEN - 1);
      while (frame_buf.size() > len) void'(frame_buf.pop_back());
    end else if (pick >= 92 && pick < 96) begin
      repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
    end else if (pick >= 96) begin
      frame_buf = {};
      repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom));
    end
    send_frame();
  endtask

  initial begin : result_sink
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_results = 0;
      end
      stall = calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [7:0] a, b, c, d;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    rx_ch.frame_end = 1'b0;
    res_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    wrap_up = 1'b0;
    calm = 0;
    hold_results = 0;
    bytes_sent = 0;
    settings_used = 0;
    cur_ver = 8'd1;
    cur_kind_lo = 8'd0;
    cur_kind_hi = 8'd2;
    cur_mode_lo = 8'd0;
    cur_mode_hi = 8'd3;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames under the reset settings.
    frame_buf = '{MAGIC_0};
    send_frame();
    build_frame(8'd0, 8'd0, FILL_ZERO);
    send_frame();
    build_frame(8'd2, 8'd3, FILL_ONES);
    send_frame();
    build_frame(8'd1, 8'd2, FILL_MIN);
    send_frame();
    build_frame(8'd2, 8'd0, FILL_MAX);
    send_frame();
    build_frame(8'd0, 8'd0, FILL_RANDOM);
    frame_buf[0] = 8'h00;
    send_frame();
    // Magic and CRC both wrong: the magic fault has priority.
    build_frame(8'd0, 8'd0, FILL_RANDOM);
    frame_buf[1] = 8'hFF;
    frame_buf[CRC_LAST] ^= 8'h01;
    send_frame();
    build_frame(8'd3, 8'd0, FILL_RANDOM);
    frame_buf[2] = 8'h02;
    send_frame();
    build_frame(8'd200, 8'd0, FILL_RANDOM);
    frame_buf[CRC_LAST] ^= 8'h80;
    send_frame();
    build_frame(8'd3, 8'd0, FILL_RANDOM);
    send_frame();
    build_frame(8'd0, 8'd4, FILL_RANDOM);
    send_frame();
    build_frame(8'd255, 8'd255, FILL_RANDOM);
    send_frame();
    build_frame(8'd1, 8'd1, FILL_RANDOM);
    void'(frame_buf.pop_back());
    send_frame();
    build_frame(8'd1, 8'd1, FILL_RANDOM);
    frame_buf.push_back(8'h5A);
    frame_buf.push_back(8'hA5);
    send_frame();

    // Wide-open ranges while the result side holds off and the byte side keeps pushing.
    apply_settings(8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF);
    hold_results = 1;
    calm = 1;
    repeat (4) random_frame();
    calm = 0;

    apply_settings(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
    repeat (1) random_frame();

    // Empty ranges reject every kind and mode.
    apply_settings(8'h5A, 8'hC8, 8'h64, 8'h80, 8'h7F);
    repeat (1) random_frame();

    repeat (3) begin
      a = 8'($urandom);
      b = 8'($urandom);
      c = 8'($urandom);
      d = 8'($urandom);
      if (a > b && $urandom_range(0, 9) != 0) {a, b} = {b, a};
      if (c > d && $urandom_range(0, 9) != 0) {c, d} = {d, c};
      apply_settings(8'($urandom), a, b, c, d);
      calm = ($urandom_range(0, 2) == 0);
      repeat (1) random_frame();
    end
    calm = 0;

    apply_settings(8'd1, 8'd0, 8'd2, 8'd0, 8'd3);
    repeat (1) random_frame();

    wait_drained();
    repeat (10) @(negedge clk);
    wrap_up <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    $display("Sent %0d bytes under %0d register settings besides reset; %0d frames decoded,",
             bytes_sent, settings_used, frames_checked);
    $display("%0d of them passing every check, the rest hitting each status code.", frames_ok);
    if (mismatches == 0 && frames_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
